// File: rtl/core/iracfd_pkg.sv
// shared types and constants for the infrared air conditioner frame decoder
package iracfd_pkg;

	localparam int unsigned DUR_W         = 16;
	localparam int unsigned THR_W         = 15;
	localparam int unsigned CNT_W         = 8;
	localparam int unsigned FRAME_BITS    = 72;

	localparam logic [CNT_W-1:0] FRAME_SAMPLES   = 8'd147;
	localparam logic [CNT_W-1:0] FIRST_BIT_INDEX = 8'd3;
	localparam logic [CNT_W-1:0] LAST_BIT_INDEX  = 8'd145;

	localparam logic [THR_W-1:0] THRESHOLD_RESET = 15'd1300;

	localparam logic [7:0] BYTE1_OFF   = 8'h00;
	localparam logic [7:0] BYTE1_ON    = 8'h90;
	localparam logic [7:0] TEMP_BASE   = 8'd30;
	localparam logic [7:0] TEMP_BIAS   = 8'h9E;
	localparam logic [7:0] TEMP_RESET  = 8'd50;
	localparam int unsigned MODE_FLAG_BIT = 6;

	localparam logic [3:0] FAN_CODE_LOW   = 4'h2;
	localparam logic [3:0] FAN_CODE_MED   = 4'h6;
	localparam logic [3:0] FAN_CODE_HIGH  = 4'h8;
	localparam logic [3:0] SWING_CODE_AUTO = 4'h0;
	localparam logic [3:0] SWING_CODE_MIN  = 4'h2;
	localparam logic [3:0] SWING_CODE_MAX  = 4'hA;

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_COOL = 2'd1,
		MODE_DRY  = 2'd2,
		MODE_FAN  = 2'd3
	} ac_mode_t;

	typedef enum logic [1:0] {
		FAN_AUTO = 2'd0,
		FAN_LOW  = 2'd1,
		FAN_MED  = 2'd2,
		FAN_HIGH = 2'd3
	} fan_t;

	typedef struct packed {
		ac_mode_t          mode;
		logic signed [7:0] temp;
		fan_t              fan;
		logic [2:0]        swing;
	} ac_state_t;

	typedef struct packed {
		logic signed [DUR_W-1:0] duration;
		logic                    last;
	} in_item_t;

	typedef struct packed {
		logic              frame_ok;
		logic              accepted;
		logic [1:0]        ac_mode;
		logic signed [7:0] temp_half_deg;
		logic [1:0]        fan_speed;
		logic [2:0]        swing_level;
		logic [63:0]       frame_head;
		logic [7:0]        frame_tail;
	} out_item_t;

endpackage

// File: rtl/core/iracfd_frame_dec.sv
// decodes a collected 72-bit frame into the new unit state and the result transaction
module iracfd_frame_dec (
	input  logic [iracfd_pkg::FRAME_BITS-1:0] frame_bits,
	input  logic                              frame_ok,
	input  iracfd_pkg::ac_state_t             ac_cur,
	output iracfd_pkg::ac_state_t             ac_nxt,
	output iracfd_pkg::out_item_t             result
);
	import iracfd_pkg::*;

	logic [7:0] b1, b2, b3, b4, b5, b6;
	logic [3:0] fan_nib;
	logic [3:0] swing_code;
	logic [7:0] temp_new;
	logic       accepted;

	assign b1 = frame_bits[63:56];
	assign b2 = frame_bits[55:48];
	assign b3 = frame_bits[47:40];
	assign b4 = frame_bits[39:32];
	assign b5 = frame_bits[31:24];
	assign b6 = frame_bits[23:16];

	assign fan_nib    = b3[7:4];
	assign swing_code = b5[7:4];
	assign temp_new   = b2 + TEMP_BASE - TEMP_BIAS;

	always_comb begin
		ac_nxt   = ac_cur;
		accepted = 1'b0;
		priority if (!frame_ok) begin
			accepted = 1'b0;
		end else if (b1 == BYTE1_OFF) begin
			accepted    = 1'b1;
			ac_nxt.mode = MODE_OFF;
			ac_nxt.temp = temp_new;
			ac_nxt.fan  = FAN_AUTO;
		end else if (b1 == BYTE1_ON) begin
			accepted    = 1'b1;
			ac_nxt.temp = temp_new;
			priority if (b4[MODE_FLAG_BIT] && !b6[MODE_FLAG_BIT]) begin
				ac_nxt.mode = MODE_FAN;
			end else if (!b4[MODE_FLAG_BIT] && b6[MODE_FLAG_BIT]) begin
				ac_nxt.mode = MODE_DRY;
			end else begin
				ac_nxt.mode = MODE_COOL;
			end
			unique case (fan_nib)
				FAN_CODE_LOW:  ac_nxt.fan = FAN_LOW;
				FAN_CODE_MED:  ac_nxt.fan = FAN_MED;
				FAN_CODE_HIGH: ac_nxt.fan = FAN_HIGH;
				default:       ac_nxt.fan = FAN_AUTO;
			endcase
			// even codes map to fixed positions, odd or out of range codes keep the old one
			priority if (swing_code == SWING_CODE_AUTO) begin
				ac_nxt.swing = 3'd0;
			end else if (swing_code >= SWING_CODE_MIN && swing_code <= SWING_CODE_MAX
					&& !swing_code[0]) begin
				ac_nxt.swing = swing_code[3:1];
			end else begin
				ac_nxt.swing = ac_cur.swing;
			end
		end else begin
			accepted = 1'b0;
		end
	end

	always_comb begin
		result.frame_ok      = frame_ok;
		result.accepted      = accepted;
		result.ac_mode       = ac_nxt.mode;
		result.temp_half_deg = ac_nxt.temp;
		result.fan_speed     = ac_nxt.fan;
		result.swing_level   = ac_nxt.swing;
		result.frame_head    = frame_ok ? frame_bits[71:8] : 64'd0;
		result.frame_tail    = frame_ok ? frame_bits[7:0] : 8'd0;
	end

endmodule

// File: rtl/core/ir_ac_frame_decoder_top.sv
// top level of the infrared air conditioner frame decoder
// Takes one signed mark/space duration per transaction and emits one result transaction
// on each transaction flagged last. A sample is compared against the threshold on entry and
// registered; the next stage updates the sample count, the 72-bit frame shift register and,
// at the end of a capture, the decoded unit state, all in the same cycle, writing the result
// register. One sample is accepted every cycle; only a last sample waits, and only while the
// result register is still full and stalled.
module ir_ac_frame_decoder_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  iracfd_pkg::in_item_t                 in_item,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output iracfd_pkg::out_item_t                out_result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [iracfd_pkg::THR_W-1:0]         cfg_data
);
	import iracfd_pkg::*;

	logic [THR_W-1:0]      thr_q;
	logic [DUR_W:0]        dur_ext;
	logic [DUR_W:0]        mag;
	logic                  bit_in;

	logic                  valid_s1;
	logic                  bit_s1;
	logic                  last_s1;
	logic                  fire;

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_inc;
	logic [FRAME_BITS-1:0] shift_q;
	logic [FRAME_BITS-1:0] shift_nx;
	logic                  take_bit;
	logic                  frame_ok;

	ac_state_t             ac_q;
	ac_state_t             ac_nxt;
	out_item_t             result;
	out_item_t             out_q;
	logic                  out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// magnitude compare on entry
	assign dur_ext = {in_item.duration[DUR_W-1], in_item.duration};
	assign mag     = dur_ext[DUR_W] ? (~dur_ext + {{DUR_W{1'b0}}, 1'b1}) : dur_ext;
	assign bit_in  = mag >= {{(DUR_W+1-THR_W){1'b0}}, thr_q};

	assign fire     = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			bit_s1  <= bit_in;
			last_s1 <= in_item.last;
		end
	end

	assign take_bit  = (count_q >= FIRST_BIT_INDEX) && (count_q <= LAST_BIT_INDEX) && count_q[0];
	assign shift_nx  = take_bit ? {shift_q[FRAME_BITS-2:0], bit_s1} : shift_q;
	assign count_inc = (count_q < FRAME_SAMPLES) ? count_q + 8'd1 : count_q;
	assign frame_ok  = count_inc == FRAME_SAMPLES;

	iracfd_frame_dec u_dec (
		.frame_bits (shift_nx),
		.frame_ok   (frame_ok),
		.ac_cur     (ac_q),
		.ac_nxt     (ac_nxt),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			shift_q <= '0;
			ac_q    <= '{mode: MODE_OFF, temp: TEMP_RESET, fan: FAN_AUTO, swing: 3'd0};
		end else if (fire) begin
			if (last_s1) begin
				count_q <= '0;
				shift_q <= '0;
				ac_q    <= ac_nxt;
			end else begin
				count_q <= count_inc;
				shift_q <= shift_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_s1) begin
			out_q <= result;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_result = out_q;

	a_accept_needs_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_result.frame_ok || !out_result.accepted))
		else $error("accepted result without a complete frame");

	a_short_frame_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_result.frame_ok) |->
		(out_result.frame_head == 64'd0 && out_result.frame_tail == 8'd0))
		else $error("short capture carries frame bytes");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FRAME_SAMPLES)
		else $error("sample count past saturation");

	a_capture_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && last_s1) |=> (count_q == '0 && shift_q == '0))
		else $error("capture not cleared after last sample");

	a_off_fan_auto: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_result.accepted && out_result.ac_mode == MODE_OFF) |->
		(out_result.fan_speed == FAN_AUTO))
		else $error("off frame left fan not auto");

endmodule
